/* design/iem_pkg.sv */
// Shared types, codes and helpers for the I2C EEPROM master sequencer.
package iem_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int LEN_W        = 6;
    localparam int LEN_CMP_W    = (PTR_W > LEN_W) ? PTR_W : LEN_W;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Item modes.
    localparam logic [1:0] MODE_STATUS = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_BEGIN  = 2'd3;

    // Bus controller status codes.
    localparam logic [3:0] ST_START    = 4'd0;
    localparam logic [3:0] ST_RSTART   = 4'd1;
    localparam logic [3:0] ST_AW_ACK   = 4'd2;
    localparam logic [3:0] ST_AW_NACK  = 4'd3;
    localparam logic [3:0] ST_TX_ACK   = 4'd4;
    localparam logic [3:0] ST_TX_NACK  = 4'd5;
    localparam logic [3:0] ST_ARB_LOST = 4'd6;
    localparam logic [3:0] ST_AR_ACK   = 4'd7;
    localparam logic [3:0] ST_AR_NACK  = 4'd8;
    localparam logic [3:0] ST_RX_ACK   = 4'd9;
    localparam logic [3:0] ST_RX_NACK  = 4'd10;

    // Operations handed from the front end to the execution engine.
    localparam logic [3:0] OP_LOAD     = 4'd0;
    localparam logic [3:0] OP_READ     = 4'd1;
    localparam logic [3:0] OP_BEGIN    = 4'd2;
    localparam logic [3:0] OP_START    = 4'd3;
    localparam logic [3:0] OP_RSTART   = 4'd4;
    localparam logic [3:0] OP_AW_ACK   = 4'd5;
    localparam logic [3:0] OP_AW_NACK  = 4'd6;
    localparam logic [3:0] OP_TX_ACK   = 4'd7;
    localparam logic [3:0] OP_TX_NACK  = 4'd8;
    localparam logic [3:0] OP_ARB_LOST = 4'd9;
    localparam logic [3:0] OP_AR_ACK   = 4'd10;
    localparam logic [3:0] OP_AR_NACK  = 4'd11;
    localparam logic [3:0] OP_RX_ACK   = 4'd12;
    localparam logic [3:0] OP_RX_NACK  = 4'd13;
    localparam logic [3:0] OP_BAD      = 4'd14;

    // Start and stop flag actions.
    localparam logic [1:0] CTL_NONE  = 2'd0;
    localparam logic [1:0] CTL_CLEAR = 2'd1;
    localparam logic [1:0] CTL_SET   = 2'd2;

    // Acknowledge flag actions.
    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_NACK = 2'd1;
    localparam logic [1:0] ACK_ACK  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_DATA_NACK  = 3'd1;
    localparam logic [2:0] ERR_ARB_LOST   = 3'd2;
    localparam logic [2:0] ERR_NO_SLAVE   = 3'd3;
    localparam logic [2:0] ERR_BAD_STATUS = 3'd4;

    // Address phase codes.
    localparam logic [1:0] PH_DATA      = 2'd0;
    localparam logic [1:0] PH_ADDR_LOW  = 2'd1;
    localparam logic [1:0] PH_ADDR_HIGH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SLAVE_CMD = 2'd0;
    localparam logic [1:0] REG_ADDR_HIGH = 2'd1;
    localparam logic [1:0] REG_ADDR_LOW  = 2'd2;
    localparam logic [1:0] REG_LENGTH    = 2'd3;

    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [7:0] READ_BIT_MASK   = 8'h01;

    typedef struct packed {
        logic [3:0]        op;
        logic [7:0]        data;
        logic [BUF_AW-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       slave_command;
        logic [7:0]       mem_addr_high;
        logic [7:0]       mem_addr_low;
        logic [LEN_W-1:0] transfer_length;
    } cfg_t;

    // Folds a five-bit buffer index onto the buffer depth.
    function automatic logic [BUF_AW-1:0] wrap_index(input logic [4:0] i);
        logic [BUF_AW-1:0] r;
        r = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (i == 5'(k))
            begin
                r = BUF_AW'(k % BUFFER_DEPTH);
            end
        end
        return r;
    endfunction

endpackage

/* design/iem_in_if.sv */
// Request channel carrying one sequencer input item.
interface iem_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] bus_status;
    logic [7:0] rx_byte;
    logic [4:0] buf_index;
    logic [7:0] buf_byte;

    modport source (output valid, mode, bus_status, rx_byte, buf_index, buf_byte,
                    input ready);
    modport sink   (input valid, mode, bus_status, rx_byte, buf_index, buf_byte,
                    output ready);
endinterface

/* design/iem_out_if.sv */
// Request channel carrying one sequencer result item.
interface iem_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] start_ctl;
    logic [1:0] stop_ctl;
    logic [1:0] ack_ctl;
    logic       busy_res;
    logic [2:0] error_code;
    logic [7:0] read_byte;

    modport source (output valid, tx_valid, tx_byte, start_ctl, stop_ctl, ack_ctl,
                    busy_res, error_code, read_byte, input ready);
    modport sink   (input valid, tx_valid, tx_byte, start_ctl, stop_ctl, ack_ctl,
                    busy_res, error_code, read_byte, output ready);
endinterface

/* design/iem_ram.sv */
// Generic single-port RAM with registered read data.
module iem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/iem_front.sv */
// Front end: takes input requests and classifies them into engine operations.
module iem_front
    import iem_pkg::*;
(
    iem_in_if.sink item,
    output cmd_t   cmd,
    output logic   cmd_valid,
    input  logic   cmd_ready
);

    logic [3:0] op;

    always_comb
    begin
        op = OP_BAD;
        unique case (item.mode)
            MODE_LOAD:  op = OP_LOAD;
            MODE_READ:  op = OP_READ;
            MODE_BEGIN: op = OP_BEGIN;
            MODE_STATUS:
            begin
                unique case (item.bus_status)
                    ST_START:    op = OP_START;
                    ST_RSTART:   op = OP_RSTART;
                    ST_AW_ACK:   op = OP_AW_ACK;
                    ST_AW_NACK:  op = OP_AW_NACK;
                    ST_TX_ACK:   op = OP_TX_ACK;
                    ST_TX_NACK:  op = OP_TX_NACK;
                    ST_ARB_LOST: op = OP_ARB_LOST;
                    ST_AR_ACK:   op = OP_AR_ACK;
                    ST_AR_NACK:  op = OP_AR_NACK;
                    ST_RX_ACK:   op = OP_RX_ACK;
                    ST_RX_NACK:  op = OP_RX_NACK;
                    default:     op = OP_BAD;
                endcase
            end
        endcase
    end

    // Load requests carry the buffer byte, receive events the bus byte.
    assign cmd.op    = op;
    assign cmd.data  = (item.mode == MODE_LOAD) ? item.buf_byte : item.rx_byte;
    assign cmd.idx   = wrap_index(item.buf_index);
    assign cmd_valid = item.valid;
    assign item.ready = cmd_ready;

endmodule

/* design/iem_queue.sv */
// Short FIFO of classified operations between the front end and the engine.
module iem_queue
    import iem_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t wr_cmd,
    input  logic wr_valid,
    output logic wr_ready,
    output cmd_t rd_cmd,
    output logic rd_valid,
    input  logic rd_ready
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign wr_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(wr_ptr_reg + QPTR_W'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(rd_ptr_reg + QPTR_W'(1));
        end
        priority if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + QCNT_W'(1));
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - QCNT_W'(1));
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

/* design/iem_back.sv */
// Execution engine: transfer state, data buffer and the registered result stage.
module iem_back
    import iem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    iem_out_if.source result
);

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       phase_reg, phase_next;
    logic             busy_reg, busy_next;
    logic [2:0]       err_reg, err_next;

    // Result stage.
    logic             res_valid_reg;
    logic             txv_reg, txv_next;
    logic [7:0]       tx_reg, tx_next;
    logic             tx_ram_reg, tx_ram_next;
    logic             rd_ram_reg, rd_ram_next;
    logic [1:0]       sta_reg, sta_next;
    logic [1:0]       sto_reg, sto_next;
    logic [1:0]       ack_reg, ack_next;

    logic              fire;
    logic              ptr_ok;
    logic [PTR_W-1:0]  ptr_inc;
    logic [PTR_W-1:0]  cnt_dec;
    logic [LEN_CMP_W-1:0] len_ext;
    logic [PTR_W-1:0]  len_sat;
    logic              ram_en, ram_we;
    logic [BUF_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;

    assign cmd_ready = !res_valid_reg || result.ready;
    assign fire      = cmd_valid && cmd_ready;

    assign ptr_ok  = ptr_reg < PTR_W'(BUFFER_DEPTH);
    assign ptr_inc = ptr_ok ? PTR_W'(ptr_reg + PTR_W'(1)) : ptr_reg;
    assign cnt_dec = (cnt_reg != '0) ? PTR_W'(cnt_reg - PTR_W'(1)) : '0;
    assign len_ext = LEN_CMP_W'(cfg.transfer_length);

    always_comb
    begin
        priority if (len_ext == '0)
        begin
            len_sat = PTR_W'(1);
        end
        else if (len_ext > LEN_CMP_W'(BUFFER_DEPTH))
        begin
            len_sat = PTR_W'(BUFFER_DEPTH);
        end
        else
        begin
            len_sat = PTR_W'(len_ext);
        end
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        busy_next   = busy_reg;
        err_next    = err_reg;
        txv_next    = 1'b0;
        tx_next     = '0;
        tx_ram_next = 1'b0;
        rd_ram_next = 1'b0;
        sta_next    = CTL_NONE;
        sto_next    = CTL_NONE;
        ack_next    = ACK_NONE;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = cmd.idx;
        ram_wdata   = cmd.data;

        if (fire)
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    ram_en = 1'b1;
                    ram_we = 1'b1;
                end
                OP_READ:
                begin
                    ram_en      = 1'b1;
                    rd_ram_next = 1'b1;
                end
                OP_BEGIN:
                begin
                    cnt_next   = len_sat;
                    phase_next = PH_ADDR_HIGH;
                    ptr_next   = '0;
                    err_next   = ERR_NONE;
                    busy_next  = 1'b1;
                    sta_next   = CTL_SET;
                end
                OP_START:
                begin
                    txv_next = 1'b1;
                    tx_next  = cfg.slave_command & ADDR_WRITE_MASK;
                    sta_next = CTL_CLEAR;
                end
                OP_RSTART:
                begin
                    txv_next = 1'b1;
                    tx_next  = cfg.slave_command;
                    sta_next = CTL_CLEAR;
                end
                OP_AW_ACK:
                begin
                    txv_next = 1'b1;
                    tx_next  = cfg.mem_addr_high;
                end
                OP_AW_NACK:
                begin
                    sto_next = CTL_SET;
                    sta_next = CTL_SET;
                end
                OP_TX_ACK:
                begin
                    unique case (phase_reg)
                        PH_ADDR_HIGH:
                        begin
                            txv_next   = 1'b1;
                            tx_next    = cfg.mem_addr_low;
                            phase_next = PH_ADDR_LOW;
                        end
                        PH_ADDR_LOW:
                        begin
                            if ((cfg.slave_command & READ_BIT_MASK) != '0)
                            begin
                                sto_next = CTL_CLEAR;
                                sta_next = CTL_SET;
                            end
                            else
                            begin
                                txv_next    = 1'b1;
                                tx_ram_next = ptr_ok;
                                ram_en      = ptr_ok;
                                ram_addr    = ptr_reg[BUF_AW-1:0];
                                ptr_next    = ptr_inc;
                                phase_next  = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            cnt_next = cnt_dec;
                            if (cnt_dec != '0)
                            begin
                                txv_next    = 1'b1;
                                tx_ram_next = ptr_ok;
                                ram_en      = ptr_ok;
                                ram_addr    = ptr_reg[BUF_AW-1:0];
                                ptr_next    = ptr_inc;
                            end
                            else
                            begin
                                sto_next  = CTL_SET;
                                busy_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_TX_NACK:
                begin
                    err_next  = ERR_DATA_NACK;
                    sto_next  = CTL_SET;
                    busy_next = 1'b0;
                end
                OP_ARB_LOST:
                begin
                    err_next  = ERR_ARB_LOST;
                    sto_next  = CTL_SET;
                    busy_next = 1'b0;
                end
                OP_AR_ACK:
                begin
                    cnt_next = cnt_dec;
                    ack_next = (cnt_dec != '0) ? ACK_ACK : ACK_NACK;
                end
                OP_AR_NACK:
                begin
                    err_next  = ERR_NO_SLAVE;
                    sto_next  = CTL_SET;
                    busy_next = 1'b0;
                end
                OP_RX_ACK:
                begin
                    cnt_next = cnt_dec;
                    ram_en   = ptr_ok;
                    ram_we   = 1'b1;
                    ram_addr = ptr_reg[BUF_AW-1:0];
                    ptr_next = ptr_inc;
                    ack_next = (cnt_dec != '0) ? ACK_ACK : ACK_NACK;
                end
                OP_RX_NACK:
                begin
                    ram_en    = ptr_ok;
                    ram_we    = 1'b1;
                    ram_addr  = ptr_reg[BUF_AW-1:0];
                    sto_next  = CTL_SET;
                    busy_next = 1'b0;
                end
                default:
                begin
                    err_next  = ERR_BAD_STATUS;
                    sto_next  = CTL_SET;
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    iem_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            phase_reg     <= PH_ADDR_HIGH;
            busy_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            err_reg   <= err_next;
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            txv_reg    <= txv_next;
            tx_reg     <= tx_next;
            tx_ram_reg <= tx_ram_next;
            rd_ram_reg <= rd_ram_next;
            sta_reg    <= sta_next;
            sto_reg    <= sto_next;
            ack_reg    <= ack_next;
        end
    end

    // The buffer read register holds while the result waits, because the
    // RAM is only enabled when a new operation is taken.
    assign result.valid      = res_valid_reg;
    assign result.tx_valid   = txv_reg;
    assign result.tx_byte    = tx_ram_reg ? ram_rdata : tx_reg;
    assign result.start_ctl  = sta_reg;
    assign result.stop_ctl   = sto_reg;
    assign result.ack_ctl    = ack_reg;
    assign result.busy_res   = busy_reg;
    assign result.error_code = err_reg;
    assign result.read_byte  = rd_ram_reg ? ram_rdata : '0;

    a_begin_inits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.op == OP_BEGIN |=> busy_reg && err_reg == ERR_NONE
            && ptr_reg == '0 && cnt_reg != '0)
        else $error("begin transfer did not initialize the engine");

    a_nack_stops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.op == OP_TX_NACK |=> !busy_reg && err_reg == ERR_DATA_NACK
            && result.valid && result.stop_ctl == CTL_SET)
        else $error("data NACK did not stop the transfer");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(BUFFER_DEPTH) && cnt_reg <= PTR_W'(BUFFER_DEPTH))
        else $error("buffer pointer or length counter out of range");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA || phase_reg == PH_ADDR_LOW || phase_reg == PH_ADDR_HIGH)
        else $error("address phase left the sequence");

endmodule

/* design/i2c_eeprom_master_sequencer.sv */
// Top level of the I2C EEPROM master sequencer with its configuration port.
//
// The sequencer takes one request per item on the item channel (a bus
// controller status event, a buffer load, a buffer readback or a begin
// transfer command) and returns exactly one result per item on the result
// channel: the next byte to transmit, the start, stop and acknowledge flag
// actions, busy and a sticky error code. It sustains one item per clock
// cycle while the result channel is ready; an item passes the two-entry
// operation queue and the result register of the execution engine, whose
// single-port 32-byte data buffer is read or written at most once per item
// and returns its data from a register. The item channel keeps taking
// requests while a result waits, until the queue is full. A slave-address
// NACK on the write address sets stop and start so that the transfer
// restarts; data NACKs, read-address NACKs, lost arbitration and unknown
// status codes set stop, clear busy and record an error that stays until
// the next begin transfer. The buffer is not cleared at reset, so an entry
// must be written before it is read back or transmitted. APB registers sit
// at byte addresses 0 (slave command), 4 (memory address high), 8 (memory
// address low) and 12 (transfer length, taken within 1 to 32); the user must
// write them only while no item is in flight; the block does not enforce it.
module i2c_eeprom_master_sequencer
    import iem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    iem_in_if.sink      item,
    iem_out_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]       slave_command_reg;
    logic [7:0]       mem_addr_high_reg;
    logic [7:0]       mem_addr_low_reg;
    logic [LEN_W-1:0] transfer_length_reg;
    logic             cfg_write;
    logic [1:0]       reg_index;
    cfg_t             cfg;

    cmd_t front_cmd;
    logic front_valid, front_ready;
    cmd_t queue_cmd;
    logic queue_valid, queue_ready;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_command_reg   <= 8'd160;
            mem_addr_high_reg   <= 8'd0;
            mem_addr_low_reg    <= 8'd0;
            transfer_length_reg <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_SLAVE_CMD: slave_command_reg   <= pwdata[7:0];
                REG_ADDR_HIGH: mem_addr_high_reg   <= pwdata[7:0];
                REG_ADDR_LOW:  mem_addr_low_reg    <= pwdata[7:0];
                REG_LENGTH:    transfer_length_reg <= pwdata[LEN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_SLAVE_CMD: prdata = 32'(slave_command_reg);
            REG_ADDR_HIGH: prdata = 32'(mem_addr_high_reg);
            REG_ADDR_LOW:  prdata = 32'(mem_addr_low_reg);
            REG_LENGTH:    prdata = 32'(transfer_length_reg);
        endcase
    end

    assign cfg.slave_command   = slave_command_reg;
    assign cfg.mem_addr_high   = mem_addr_high_reg;
    assign cfg.mem_addr_low    = mem_addr_low_reg;
    assign cfg.transfer_length = transfer_length_reg;

    // Classification of incoming requests.
    iem_front u_front (
        .item      (item),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // Decouples request intake from the engine and the result stall.
    iem_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_cmd   (queue_cmd),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready)
    );

    // Transfer state, data buffer and result register.
    iem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .result    (result)
    );

endmodule
